// File: design/lca_pkg.sv
// Shared types, constants and helpers for the Life cellular automaton block.
// Used by lca_ctrl, lca_datapath and life_cellular_automaton; depends on nothing else.
package lca_pkg;

  // Default grid size.
  localparam int LCA_GRID_WIDTH  = 240;
  localparam int LCA_GRID_HEIGHT = 320;

  // Field widths of the input and result beats.
  localparam int OP_W    = 2;
  localparam int COL_W   = 8;
  localparam int ROW_W   = 9;
  localparam int PIXEL_W = 16;

  // Signed coordinate width for seed points, wide enough for any grid plus offset.
  localparam int COORD_W = 12;

  // Seed pattern: the point itself and four diagonal points.
  localparam int SEED_PTS   = 5;
  localparam int SEED_IDX_W = 3;
  localparam logic signed [COORD_W-1:0] SEED_OFF = COORD_W'(2);

  // Pixel codes and Life rule counts.
  localparam logic [PIXEL_W-1:0] LIVE_PIXEL    = 16'hFFFF;
  localparam logic [PIXEL_W-1:0] DEAD_PIXEL    = 16'h0000;
  localparam logic [3:0]         BIRTH_COUNT   = 4'd3;
  localparam logic [3:0]         SURVIVE_COUNT = 4'd2;

  // Operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_SEED = 2'd0,
    OP_STEP = 2'd1,
    OP_READ = 2'd2
  } op_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEED,
    ST_STEP,
    ST_READ,
    ST_DRAIN,
    ST_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic clr_en;
    logic seed_en;
    logic scan_en;
    logic read_en;
    logic finish;
  } lca_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic seed_last;
    logic scan_last;
    logic pipe_busy;
  } lca_stat_t;

  // Column offset of seed point k.
  function automatic logic signed [COORD_W-1:0] seed_dx(input logic [SEED_IDX_W-1:0] k);
    logic signed [COORD_W-1:0] d;
    case (k)
      3'd1, 3'd3: d = -SEED_OFF;
      3'd2, 3'd4: d = SEED_OFF;
      default:    d = '0;
    endcase
    return d;
  endfunction

  // Row offset of seed point k.
  function automatic logic signed [COORD_W-1:0] seed_dy(input logic [SEED_IDX_W-1:0] k);
    logic signed [COORD_W-1:0] d;
    case (k)
      3'd1, 3'd2: d = -SEED_OFF;
      3'd3, 3'd4: d = SEED_OFF;
      default:    d = '0;
    endcase
    return d;
  endfunction

endpackage

// File: design/lca_ctrl.sv
// Controller state machine of the Life cellular automaton block.
// Depends on lca_pkg; drives commands into lca_datapath and reads its status.
module lca_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [lca_pkg::OP_W-1:0]     in_operation,
  input  lca_pkg::lca_stat_t           stat,
  output lca_pkg::lca_cmd_t            cmd,
  output logic                         busy
);
  import lca_pkg::*;

  state_t state_r, state_nxt;

  // State register; reset starts the grid clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          case (op_t'(in_operation))
            OP_SEED: state_nxt = ST_SEED;
            OP_STEP: state_nxt = ST_STEP;
            OP_READ: state_nxt = ST_READ;
            default: state_nxt = ST_RESP;
          endcase
        end
      end
      ST_SEED: begin
        if (stat.seed_last) state_nxt = ST_DRAIN;
      end
      ST_STEP: begin
        if (stat.scan_last) state_nxt = ST_DRAIN;
      end
      ST_READ: begin
        state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) state_nxt = ST_RESP;
      end
      ST_RESP: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Command outputs decoded from the state.
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_CLEAR: cmd.clr_en = 1'b1;
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_SEED:  cmd.seed_en = 1'b1;
      ST_STEP:  cmd.scan_en = 1'b1;
      ST_READ:  cmd.read_en = 1'b1;
      ST_DRAIN: cmd = '0;
      ST_RESP:  cmd.finish = 1'b1;
      default:  cmd = '0;
    endcase
  end

endmodule

// File: design/lca_datapath.sv
// Datapath of the Life cellular automaton block: cell grid memory, line buffer,
// neighbor window, seed and read address unit, scan counters and result register.
// Depends on lca_pkg; controlled by lca_ctrl.
module lca_datapath #(
  parameter int GRID_WIDTH  = lca_pkg::LCA_GRID_WIDTH,
  parameter int GRID_HEIGHT = lca_pkg::LCA_GRID_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lca_pkg::lca_cmd_t             cmd,
  output lca_pkg::lca_stat_t            stat,
  input  logic [lca_pkg::COL_W-1:0]     in_col_pos,
  input  logic [lca_pkg::ROW_W-1:0]     in_row_pos,
  output logic                          out_valid,
  output logic [lca_pkg::PIXEL_W-1:0]   out_pixel_value,
  output logic                          out_cell_live
);
  import lca_pkg::*;

  localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam int SAW   = $clog2(CELLS + GRID_WIDTH);
  localparam int XW    = $clog2(GRID_WIDTH);
  localparam int YW    = $clog2(GRID_HEIGHT + 1);

  localparam logic [XW-1:0]  X_LAST     = XW'(GRID_WIDTH - 1);
  localparam logic [YW-1:0]  Y_LAST     = YW'(GRID_HEIGHT - 1);
  localparam logic [YW-1:0]  Y_PAD      = YW'(GRID_HEIGHT);
  localparam logic [XW-1:0]  X_TWO      = XW'(2);
  localparam logic [YW-1:0]  Y_TWO      = YW'(2);
  localparam logic [SAW-1:0] CLR_LAST   = SAW'(CELLS - 1);
  localparam logic [SAW-1:0] ROW_STRIDE = SAW'(GRID_WIDTH + 1);
  localparam logic [SEED_IDX_W-1:0] SEED_LAST = SEED_IDX_W'(SEED_PTS - 1);
  localparam logic signed [COORD_W-1:0] W_S = COORD_W'(GRID_WIDTH);
  localparam logic signed [COORD_W-1:0] H_S = COORD_W'(GRID_HEIGHT);

  // Captured input fields.
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;

  // Scan and seed counters.
  logic [XW-1:0]         x_r, x_nxt;
  logic [YW-1:0]         y_r, y_nxt;
  logic [SAW-1:0]        scan_addr_r, scan_addr_nxt;
  logic [SEED_IDX_W-1:0] k_r, k_nxt;

  // Point address unit (seed writes and cell reads).
  logic signed [COORD_W-1:0] px, py;
  logic                      pt_ok;
  logic [AW-1:0]             pt_addr;
  logic [AW-1:0]             pt_addr_r;
  logic                      pt_ok_r;
  logic                      pt_wr_r;
  logic                      pt_rd_r;
  logic                      rd_hit_r;
  logic                      res_live_r;

  // Grid memory ports.
  logic          grid_mem [CELLS];
  logic          grid_re, grid_we, grid_wd;
  logic [AW-1:0] grid_ra, grid_wa;
  logic          grid_q_r;

  // Line buffer: bit 1 holds the old row above, bit 0 the old row two above.
  logic [1:0]    lb_mem [GRID_WIDTH];
  logic [1:0]    lb_q_r;

  // Step pipeline.
  logic           s1_vld_r, s1_row_ok_r;
  logic [XW-1:0]  s1_x_r;
  logic [YW-1:0]  s1_y_r;
  logic [SAW-1:0] s1_addr_r;
  logic           s2_vld_r;
  logic [XW-1:0]  s2_x_r;
  logic [YW-1:0]  s2_y_r;
  logic [SAW-1:0] s2_addr_r;
  logic [2:0]     win_r [3];
  logic           new_bit;
  logic [2:0]     col_in;
  logic [3:0]     nbr_cnt;
  logic           center;
  logic           interior;
  logic [SAW-1:0] wr_scan_addr;

  // Result beat.
  logic out_valid_r, out_live_r;

  // Capture the item fields on accept.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_r <= in_col_pos;
      row_r <= in_row_pos;
    end
  end

  // Counter next values: raster scan for clearing and stepping, index for seeding.
  always_comb begin
    x_nxt         = x_r;
    y_nxt         = y_r;
    scan_addr_nxt = scan_addr_r;
    k_nxt         = k_r;
    if (cmd.load) begin
      x_nxt         = '0;
      y_nxt         = '0;
      scan_addr_nxt = '0;
      k_nxt         = '0;
    end else begin
      if (cmd.clr_en || cmd.scan_en) begin
        scan_addr_nxt = scan_addr_r + 1'b1;
        if (x_r == X_LAST) begin
          x_nxt = '0;
          y_nxt = y_r + 1'b1;
        end else begin
          x_nxt = x_r + 1'b1;
        end
      end
      if (cmd.seed_en) k_nxt = k_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r         <= '0;
      y_r         <= '0;
      scan_addr_r <= '0;
      k_r         <= '0;
    end else begin
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      scan_addr_r <= scan_addr_nxt;
      k_r         <= k_nxt;
    end
  end

  // Current seed or read point, its bounds check and its grid address.
  always_comb begin
    px      = $signed(COORD_W'(col_r)) + seed_dx(k_r);
    py      = $signed(COORD_W'(row_r)) + seed_dy(k_r);
    pt_ok   = !px[COORD_W-1] && (px < W_S) && !py[COORD_W-1] && (py < H_S);
    pt_addr = AW'(AW'($unsigned(py)) * AW'(GRID_WIDTH)) + AW'($unsigned(px));
  end

  // Point stage registers.
  always_ff @(posedge clk) begin
    if (cmd.seed_en || cmd.read_en) begin
      pt_addr_r <= pt_addr;
      pt_ok_r   <= pt_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_wr_r    <= 1'b0;
      pt_rd_r    <= 1'b0;
      rd_hit_r   <= 1'b0;
      res_live_r <= 1'b0;
    end else begin
      pt_wr_r  <= cmd.seed_en;
      pt_rd_r  <= cmd.read_en;
      rd_hit_r <= pt_rd_r;
      if (cmd.load) begin
        res_live_r <= 1'b0;
      end else if (rd_hit_r) begin
        res_live_r <= grid_q_r & pt_ok_r;
      end
    end
  end

  // Grid read port: scan reads for a step, one point read for a read beat.
  always_comb begin
    grid_re = (cmd.scan_en && (y_r != Y_PAD)) || (pt_rd_r && pt_ok_r);
    grid_ra = pt_rd_r ? pt_addr_r : scan_addr_r[AW-1:0];
  end

  // Neighbor count and Life rule on the window center.
  always_comb begin
    center  = win_r[1][1];
    nbr_cnt = 4'(win_r[0][0]) + 4'(win_r[0][1]) + 4'(win_r[0][2])
            + 4'(win_r[1][0]) + 4'(win_r[1][2])
            + 4'(win_r[2][0]) + 4'(win_r[2][1]) + 4'(win_r[2][2]);
    interior = (s2_x_r >= X_TWO) && (s2_y_r >= Y_TWO) && (s2_y_r <= Y_LAST);
    new_bit  = interior && ((nbr_cnt == BIRTH_COUNT) ||
                            (center && (nbr_cnt == SURVIVE_COUNT)));
    // The center sits one row up and one column left of the scan point; at the
    // start of a row the last column of the row above is written instead.
    wr_scan_addr = (s2_x_r == '0) ? (s2_addr_r - 1'b1) : (s2_addr_r - ROW_STRIDE);
  end

  // Grid write port: clearing pass, seed points, or new generation cells.
  always_comb begin
    grid_we = 1'b0;
    grid_wa = scan_addr_r[AW-1:0];
    grid_wd = 1'b0;
    if (cmd.clr_en) begin
      grid_we = 1'b1;
    end else if (pt_wr_r) begin
      grid_we = pt_ok_r;
      grid_wa = pt_addr_r;
      grid_wd = 1'b1;
    end else if (s2_vld_r && (s2_y_r != '0)) begin
      grid_we = 1'b1;
      grid_wa = wr_scan_addr[AW-1:0];
      grid_wd = new_bit;
    end
  end

  // Cell grid memory.
  always_ff @(posedge clk) begin
    if (grid_we) grid_mem[grid_wa] <= grid_wd;
  end

  always_ff @(posedge clk) begin
    if (grid_re) grid_q_r <= grid_mem[grid_ra];
  end

  // Line buffer of the two previous old rows.
  always_ff @(posedge clk) begin
    if (cmd.scan_en) lb_q_r <= lb_mem[x_r];
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r) lb_mem[s1_x_r] <= {col_in[2], lb_q_r[1]};
  end

  // New window column: old scan row, the row above and the row two above.
  always_comb begin
    col_in = {grid_q_r & s1_row_ok_r, lb_q_r[1], lb_q_r[0]};
  end

  // Step pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= cmd.scan_en;
      s2_vld_r <= s1_vld_r;
    end
  end

  // Step pipeline position and window registers.
  always_ff @(posedge clk) begin
    if (cmd.scan_en) begin
      s1_x_r      <= x_r;
      s1_y_r      <= y_r;
      s1_addr_r   <= scan_addr_r;
      s1_row_ok_r <= (y_r != Y_PAD);
    end
    if (s1_vld_r) begin
      s2_x_r    <= s1_x_r;
      s2_y_r    <= s1_y_r;
      s2_addr_r <= s1_addr_r;
      win_r[0]  <= win_r[1];
      win_r[1]  <= win_r[2];
      win_r[2]  <= col_in;
    end
  end

  // Status back to the controller.
  always_comb begin
    stat.clr_last  = (scan_addr_r == CLR_LAST);
    stat.seed_last = (k_r == SEED_LAST);
    stat.scan_last = (y_r == Y_PAD) && (x_r == X_LAST);
    stat.pipe_busy = pt_wr_r || pt_rd_r || rd_hit_r || s1_vld_r || s2_vld_r;
  end

  // Result beat register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_live_r  <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
      out_live_r  <= cmd.finish & res_live_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cell_live   = out_live_r;
  assign out_pixel_value = out_live_r ? LIVE_PIXEL : DEAD_PIXEL;

endmodule

// File: design/life_cellular_automaton.sv
// Life cellular automaton (B3/S23): a step beat is a raster scan of one cell per cycle
// through the grid memory's single read and write port.
// One beat is worked at a time; busy stays high until its result appears on out_*, and falls in that same cycle.
// After reset the block clears the grid with busy high.
// Each result is on out_* for exactly one cycle, marked by out_valid.
module life_cellular_automaton #(
  parameter int GRID_WIDTH  = lca_pkg::LCA_GRID_WIDTH,
  parameter int GRID_HEIGHT = lca_pkg::LCA_GRID_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [lca_pkg::OP_W-1:0]      in_operation,
  input  logic [lca_pkg::COL_W-1:0]     in_col_pos,
  input  logic [lca_pkg::ROW_W-1:0]     in_row_pos,
  output logic                          out_valid,
  output logic [lca_pkg::PIXEL_W-1:0]   out_pixel_value,
  output logic                          out_cell_live
);
  import lca_pkg::*;

  lca_cmd_t  cmd;
  lca_stat_t stat;

  // Controller.
  lca_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .stat         (stat),
    .cmd          (cmd),
    .busy         (busy)
  );

  // Datapath.
  lca_datapath #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_col_pos      (in_col_pos),
    .in_row_pos      (in_row_pos),
    .out_valid       (out_valid),
    .out_pixel_value (out_pixel_value),
    .out_cell_live   (out_cell_live)
  );

endmodule
